/* rtl/utf8_entity_char_decoder_unit_macros.svh */
// ---------------------------------------------------------------------------
// UTF-8 / entity decoder assertion macros
// Concurrent check wrappers on clk, with and without the rst disable.
// ---------------------------------------------------------------------------
`ifndef UTF8_ENTITY_CHAR_DECODER_UNIT_MACROS_SVH
`define UTF8_ENTITY_CHAR_DECODER_UNIT_MACROS_SVH

`ifndef ASSERT_OFF
`define UED_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);
`define UED_ASSERT_NR(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define UED_ASSERT(lbl, prop, msg)
`define UED_ASSERT_NR(lbl, prop, msg)
`endif

`endif

/* rtl/ued_pkg.sv */
// ---------------------------------------------------------------------------
// UTF-8 / entity decoder package
// Word types, decode codes and controller/datapath interface structs.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

package ued_pkg;

  localparam int ENTITY_SCAN_LIMIT_DEF = 8;
  localparam int CP_W  = 17;
  localparam int LEN_W = 4;

  localparam logic [7:0] CH_AMP   = 8'h26;
  localparam logic [7:0] CH_HASH  = 8'h23;
  localparam logic [7:0] CH_SEMI  = 8'h3B;
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_NINE  = 8'h39;
  localparam logic [7:0] LEAD2_LO = 8'hC0;
  localparam logic [7:0] LEAD3_LO = 8'hE0;
  localparam logic [7:0] LEAD4_LO = 8'hF0;
  localparam logic [7:0] TRAIL_MK = 8'hC0;
  localparam logic [7:0] TRAIL_ID = 8'h80;

  typedef struct packed {
    logic       kind;
    logic [7:0] text_byte;
  } in_word_t;

  typedef struct packed {
    logic [CP_W-1:0]  code_point;
    logic [LEN_W-1:0] source_length;
    logic             last;
  } out_word_t;

  typedef enum logic [1:0] {
    MODE_IDLE,
    MODE_UTF8,
    MODE_AMP,
    MODE_DIGITS
  } mode_t;

  typedef enum logic [1:0] {
    ACT_HOLD,
    ACT_EMIT,
    ACT_FAIL
  } dec_act_t;

  typedef struct packed {
    logic sel_redo;   // decode the saved byte from idle mode
    logic apply;      // commit the decode result to the hold state
    logic save_byte;
    logic clear_hold;
    logic flush_rst;
    logic flush_adv;
    logic load_out;
    logic out_flush;  // output word comes from the held bytes
    logic out_last;
  } ctrl_cmd_t;

  typedef struct packed {
    dec_act_t dec_act;
    logic     held_zero;
    logic     flush_last;
  } dp_status_t;

endpackage

/* rtl/utf8_entity_char_decoder_unit.sv */
// ---------------------------------------------------------------------------
// UTF-8 and decimal character reference decoder
// Turns a byte stream into code points with their source byte counts.
// ---------------------------------------------------------------------------
// A byte is taken whenever the controller is idle and the result register is
// free or being read, so plain text and completed sequences run at one byte
// per cycle unless the consumer stalls, and a byte that is only held produces
// no word. When a byte breaks a UTF-8 or "&#digits;" pattern, or an end word
// arrives, with k bytes held, the controller's flush sequencer emits the k held
// bytes one per cycle unless the consumer stalls; for a breaking byte it then
// redecodes that byte from idle mode. Every emitted word passes through the
// single result register, so a stalled consumer stalls the input as well.
`timescale 1ns / 1ps

`include "utf8_entity_char_decoder_unit_macros.svh"

module utf8_entity_char_decoder_unit
  import ued_pkg::*;
#(
  parameter int ENTITY_SCAN_LIMIT = ENTITY_SCAN_LIMIT_DEF
) (
  input  logic      clk,
  input  logic      rst,
  input  logic      text_valid,
  output logic      text_stall,
  input  in_word_t  text_word,
  output logic      char_valid,
  input  logic      char_stall,
  output out_word_t char_word
);

  ctrl_cmd_t  cmd;
  dp_status_t st;

  ued_ctrl u_ctrl (
    .clk        (clk),
    .rst        (rst),
    .text_valid (text_valid),
    .text_kind  (text_word.kind),
    .text_stall (text_stall),
    .char_valid (char_valid),
    .char_stall (char_stall),
    .st         (st),
    .cmd        (cmd)
  );

  ued_datapath #(
    .ENTITY_SCAN_LIMIT (ENTITY_SCAN_LIMIT)
  ) u_datapath (
    .clk       (clk),
    .rst       (rst),
    .text_byte (text_word.text_byte),
    .cmd       (cmd),
    .st        (st),
    .char_word (char_word)
  );

  `UED_ASSERT_NR(a_rst_no_word, rst |=> !char_valid, "result word valid after reset")
  `UED_ASSERT(a_fail_has_held, st.dec_act == ACT_FAIL |-> !st.held_zero, "break with nothing held")
  `UED_ASSERT(a_flush_stalls, text_valid && !text_stall && text_word.kind && !st.held_zero |=> text_stall, "end word with held bytes did not start flush")
  `UED_ASSERT(a_emit_word, text_valid && !text_stall && !text_word.kind && st.dec_act == ACT_EMIT |=> char_valid, "decoded byte gave no word")

endmodule

/* rtl/ued_datapath.sv */
// ---------------------------------------------------------------------------
// UTF-8 / entity decoder datapath
// Hold registers, byte decoder, decimal accumulator and result register.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module ued_datapath
  import ued_pkg::*;
#(
  parameter int ENTITY_SCAN_LIMIT = ENTITY_SCAN_LIMIT_DEF
) (
  input  logic       clk,
  input  logic       rst,
  input  logic [7:0] text_byte,
  input  ctrl_cmd_t  cmd,
  output dp_status_t st,
  output out_word_t  char_word
);

  localparam int HELD_DEPTH = ENTITY_SCAN_LIMIT - 1;
  localparam int IDX_W      = $clog2(HELD_DEPTH);
  localparam int CNT_W      = $clog2(ENTITY_SCAN_LIMIT);
  localparam logic [CNT_W:0] LIMIT_C = (CNT_W+1)'(ENTITY_SCAN_LIMIT);

  logic [7:0]       held [HELD_DEPTH];
  logic [CNT_W-1:0] cnt;
  mode_t            mode;
  logic [CP_W-1:0]  pv;
  logic [7:0]       saved;
  logic [CNT_W-1:0] flush_idx;
  out_word_t        out_reg;

  mode_t            mode_eff;
  logic [7:0]       b;
  dec_act_t         act;
  mode_t            mode_n;
  logic [CNT_W-1:0] cnt_n;
  logic             wr_en;
  logic [CP_W-1:0]  pv_n;
  logic [CP_W-1:0]  dec_cp;
  logic [LEN_W-1:0] dec_len;
  logic [CNT_W:0]   cnt_inc;
  logic [CNT_W:0]   flush_inc;
  logic [7:0]       flush_byte;

  assign mode_eff   = cmd.sel_redo ? MODE_IDLE : mode;
  assign b          = cmd.sel_redo ? saved : text_byte;
  assign cnt_inc    = {1'b0, cnt} + 1'b1;
  assign flush_inc  = {1'b0, flush_idx} + 1'b1;
  assign flush_byte = held[flush_idx[IDX_W-1:0]];

  always_comb begin
    act     = ACT_HOLD;
    mode_n  = mode;
    cnt_n   = cnt;
    wr_en   = 1'b0;
    pv_n    = pv;
    dec_cp  = {{(CP_W-8){1'b0}}, b};
    dec_len = LEN_W'(1);
    case (mode_eff)
      MODE_IDLE: begin
        if (b == CH_AMP) begin
          mode_n = MODE_AMP;
          cnt_n  = CNT_W'(1);
          wr_en  = 1'b1;
          pv_n   = '0;
        end else if (b < LEAD2_LO || b >= LEAD4_LO) begin
          act = ACT_EMIT;
        end else begin
          mode_n = MODE_UTF8;
          cnt_n  = CNT_W'(1);
          wr_en  = 1'b1;
        end
      end
      MODE_UTF8: begin
        if ((b & TRAIL_MK) != TRAIL_ID) begin
          act = ACT_FAIL;
        end else if (held[0] < LEAD3_LO && cnt == CNT_W'(1)) begin
          act     = ACT_EMIT;
          dec_cp  = {6'b0, held[0][4:0], b[5:0]};
          dec_len = LEN_W'(2);
          mode_n  = MODE_IDLE;
          cnt_n   = '0;
          pv_n    = '0;
        end else if (held[0] >= LEAD3_LO && cnt == CNT_W'(2)) begin
          act     = ACT_EMIT;
          dec_cp  = {1'b0, held[0][3:0], held[1][5:0], b[5:0]};
          dec_len = LEN_W'(3);
          mode_n  = MODE_IDLE;
          cnt_n   = '0;
          pv_n    = '0;
        end else begin
          cnt_n = cnt_inc[CNT_W-1:0];
          wr_en = 1'b1;
        end
      end
      MODE_AMP: begin
        if (b == CH_HASH) begin
          mode_n = MODE_DIGITS;
          cnt_n  = cnt_inc[CNT_W-1:0];
          wr_en  = 1'b1;
          pv_n   = '0;
        end else begin
          act = ACT_FAIL;
        end
      end
      MODE_DIGITS: begin
        if (b == CH_SEMI) begin
          act     = ACT_EMIT;
          dec_cp  = pv;
          dec_len = LEN_W'(cnt_inc);
          mode_n  = MODE_IDLE;
          cnt_n   = '0;
          pv_n    = '0;
        end else if (b >= CH_ZERO && b <= CH_NINE && cnt_inc < LIMIT_C) begin
          cnt_n = cnt_inc[CNT_W-1:0];
          wr_en = 1'b1;
          // times ten as two shifts, kept to the code point width
          pv_n  = (pv << 3) + (pv << 1) + {{(CP_W-4){1'b0}}, b[3:0]};
        end else begin
          act = ACT_FAIL;
        end
      end
      default: begin
        act = ACT_HOLD;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt       <= '0;
      mode      <= MODE_IDLE;
      pv        <= '0;
      flush_idx <= '0;
    end else begin
      if (cmd.clear_hold) begin
        cnt  <= '0;
        mode <= MODE_IDLE;
        pv   <= '0;
      end else if (cmd.apply) begin
        cnt  <= cnt_n;
        mode <= mode_n;
        pv   <= pv_n;
      end
      if (cmd.flush_rst) begin
        flush_idx <= '0;
      end else if (cmd.flush_adv) begin
        flush_idx <= flush_inc[CNT_W-1:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.apply && wr_en) begin
      held[cnt[IDX_W-1:0]] <= b;
    end
    if (cmd.save_byte) begin
      saved <= text_byte;
    end
    if (cmd.load_out) begin
      out_reg.code_point    <= cmd.out_flush ? {{(CP_W-8){1'b0}}, flush_byte} : dec_cp;
      out_reg.source_length <= cmd.out_flush ? LEN_W'(1) : dec_len;
      out_reg.last          <= cmd.out_last;
    end
  end

  assign st.dec_act    = act;
  assign st.held_zero  = (cnt == '0);
  assign st.flush_last = (flush_inc == {1'b0, cnt});
  assign char_word     = out_reg;

endmodule

/* rtl/ued_ctrl.sv */
// ---------------------------------------------------------------------------
// UTF-8 / entity decoder controller
// Accepts words, sequences the flush of held bytes and the redecode step.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module ued_ctrl
  import ued_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       text_valid,
  input  logic       text_kind,
  output logic       text_stall,
  output logic       char_valid,
  input  logic       char_stall,
  input  dp_status_t st,
  output ctrl_cmd_t  cmd
);

  typedef enum logic [1:0] {
    S_IDLE,
    S_FLUSH,
    S_REDO
  } state_t;

  state_t state, state_next;
  logic   redo_pend, redo_pend_next;
  logic   out_valid, out_valid_next;
  logic   can_emit;
  logic   accept;

  assign can_emit   = !out_valid || !char_stall;
  assign text_stall = !(state == S_IDLE && can_emit);
  assign accept     = text_valid && !text_stall;
  assign char_valid = out_valid;

  always_comb begin
    cmd            = '0;
    state_next     = state;
    redo_pend_next = redo_pend;
    cmd.sel_redo   = (state != S_IDLE);
    case (state)
      S_IDLE: begin
        if (accept) begin
          if (text_kind) begin
            if (!st.held_zero) begin
              cmd.flush_rst  = 1'b1;
              redo_pend_next = 1'b0;
              state_next     = S_FLUSH;
            end
          end else begin
            case (st.dec_act)
              ACT_EMIT: begin
                cmd.apply    = 1'b1;
                cmd.load_out = 1'b1;
                cmd.out_last = 1'b1;
              end
              ACT_HOLD: begin
                cmd.apply = 1'b1;
              end
              ACT_FAIL: begin
                cmd.save_byte  = 1'b1;
                cmd.flush_rst  = 1'b1;
                redo_pend_next = 1'b1;
                state_next     = S_FLUSH;
              end
              default: begin
                cmd.apply = 1'b0;
              end
            endcase
          end
        end
      end
      S_FLUSH: begin
        if (can_emit) begin
          cmd.load_out  = 1'b1;
          cmd.out_flush = 1'b1;
          cmd.flush_adv = 1'b1;
          // last word only if the redecoded byte will not emit one of its own
          cmd.out_last  = st.flush_last && !(redo_pend && st.dec_act == ACT_EMIT);
          if (st.flush_last) begin
            cmd.clear_hold = 1'b1;
            state_next     = redo_pend ? S_REDO : S_IDLE;
          end
        end
      end
      S_REDO: begin
        if (st.dec_act != ACT_EMIT) begin
          cmd.apply  = 1'b1;
          state_next = S_IDLE;
        end else if (can_emit) begin
          cmd.apply    = 1'b1;
          cmd.load_out = 1'b1;
          cmd.out_last = 1'b1;
          state_next   = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
    out_valid_next = cmd.load_out || (out_valid && char_stall);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      redo_pend <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      redo_pend <= redo_pend_next;
      out_valid <= out_valid_next;
    end
  end

endmodule
